### sv/ufp_pkg.sv
// ----------------------------------------------------------------------------
// ufp_pkg: shared types and codes for the UBX frame parser
// Phase codes, event codes, message kinds and the parser state and result
// records that pass between the parser core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ufp_pkg;

    // sync pair and message identifiers
    localparam logic [7:0]  SYNC_ONE      = 8'hB5;
    localparam logic [7:0]  SYNC_TWO      = 8'h62;
    localparam logic [7:0]  NAV_CLASS     = 8'h01;
    localparam logic [7:0]  PVT_IDENT     = 8'h07;
    localparam logic [7:0]  HPPOS_IDENT   = 8'h14;
    localparam logic [15:0] PVT_MIN_LEN   = 16'd48;
    localparam logic [15:0] HPPOS_MIN_LEN = 16'd36;

    // parser phase codes
    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_IDENT   = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    // result event codes
    localparam logic [2:0] EV_HUNT    = 3'd0;
    localparam logic [2:0] EV_FRAMING = 3'd1;
    localparam logic [2:0] EV_PAYLOAD = 3'd2;
    localparam logic [2:0] EV_GOOD    = 3'd3;
    localparam logic [2:0] EV_BAD     = 3'd4;

    // message kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_PVT   = 2'd1;
    localparam logic [1:0] KIND_HPPOS = 2'd2;

    localparam int DATA_W = 56;
    localparam int USER_W = 5;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  frame_class;
        logic [7:0]  frame_ident;
        logic [15:0] frame_length;
        logic [15:0] byte_count;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [7:0]  rx_sum_a;
    } t_state;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [7:0]  msg_class;
        logic [7:0]  msg_ident;
        logic [15:0] payload_index;
        logic [15:0] payload_length;
        logic [1:0]  msg_kind;
    } t_result;

endpackage

`default_nettype wire

### sv/ubx_frame_parser.sv
// ----------------------------------------------------------------------------
// ubx_frame_parser: byte-serial UBX frame parser with Fletcher-8 check
// Hunts for sync, tracks class, id, length and payload, checks the frame sum.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one receiver byte per word. Every accepted byte
//   yields exactly one result word on the master stream: an event code
//   (hunting, framing byte, payload byte, frame good, frame bad), the echoed
//   byte, the frame's class, id and declared length, the payload index and,
//   on the last checksum byte, the message kind.
//   A byte's result is registered and shows in the cycle after its accept.
//   One byte per cycle is taken while the receiver keeps up; parser state
//   and result register update together in the accepting cycle, and the
//   path between them is the state decode plus two 8-bit additions.
//   A single output register holds the result; while the receiver stalls,
//   the result holds and s_axis_tready stays high only if that register is
//   empty or being taken in the same cycle, so no word is lost or repeated.
//   Reset (i_rst_n low, synchronous) returns the parser to sync hunting with
//   all frame fields cleared and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] data_byte, [15:8] msg_class, [23:16] msg_ident,
    // [39:24] payload_index, [55:40] payload_length
    output logic [ufp_pkg::DATA_W-1:0]         m_axis_tdata,
    output logic [ufp_pkg::USER_W-1:0]         m_axis_tuser   // [2:0] event_res, [4:3] msg_kind
);
    import ufp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_valid;
    logic    accept;

    ufp_core u_core (
        .i_state  (r_state),
        .i_byte   (s_axis_tdata),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result word: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_result.payload_length, r_result.payload_index,
                            r_result.msg_ident, r_result.msg_class, r_result.data_byte};
    assign m_axis_tuser  = {r_result.msg_kind, r_result.event_res};

endmodule

`default_nettype wire

### sv/ufp_core.sv
// ----------------------------------------------------------------------------
// ufp_core: next-state and result logic of the UBX frame parser
// Takes the current parser state and one byte, returns the state after the
// byte and the result word it causes. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module ufp_core (
    input  wire ufp_pkg::t_state  i_state,
    input  wire logic [7:0]       i_byte,
    output ufp_pkg::t_state       o_state,
    output ufp_pkg::t_result      o_result
);
    import ufp_pkg::*;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic [2:0]  ev;
    logic [15:0] index;
    logic [1:0]  kind;
    logic        sums_match;

    // running Fletcher-8 sums with the current byte folded in
    assign sum_a_add  = i_state.sum_a + i_byte;
    assign sum_b_add  = i_state.sum_b + sum_a_add;
    assign len_full   = {i_byte, i_state.frame_length[7:0]};
    assign count_inc  = i_state.byte_count + 16'd1;
    assign sums_match = (i_state.rx_sum_a == i_state.sum_a) && (i_byte == i_state.sum_b);

    always_comb begin
        o_state = i_state;
        ev      = EV_HUNT;
        index   = 16'd0;
        kind    = KIND_OTHER;
        unique case (i_state.phase)
            PH_HUNT2: begin
                if (i_byte == SYNC_TWO) begin
                    o_state.frame_class  = 8'd0;
                    o_state.frame_ident  = 8'd0;
                    o_state.frame_length = 16'd0;
                    o_state.byte_count   = 16'd0;
                    o_state.sum_a        = 8'd0;
                    o_state.sum_b        = 8'd0;
                    o_state.phase        = PH_CLASS;
                end else if (i_byte != SYNC_ONE) begin
                    o_state.phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                o_state.frame_class = i_byte;
                o_state.sum_a       = sum_a_add;
                o_state.sum_b       = sum_b_add;
                o_state.phase       = PH_IDENT;
                ev                  = EV_FRAMING;
            end
            PH_IDENT: begin
                o_state.frame_ident = i_byte;
                o_state.sum_a       = sum_a_add;
                o_state.sum_b       = sum_b_add;
                o_state.phase       = PH_LEN_LO;
                ev                  = EV_FRAMING;
            end
            PH_LEN_LO: begin
                o_state.frame_length = {8'd0, i_byte};
                o_state.sum_a        = sum_a_add;
                o_state.sum_b        = sum_b_add;
                o_state.phase        = PH_LEN_HI;
                ev                   = EV_FRAMING;
            end
            PH_LEN_HI: begin
                o_state.frame_length = len_full;
                o_state.sum_a        = sum_a_add;
                o_state.sum_b        = sum_b_add;
                o_state.byte_count   = 16'd0;
                // empty payload: go straight to the checksum
                o_state.phase        = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                ev                   = EV_FRAMING;
            end
            PH_PAYLOAD: begin
                index              = i_state.byte_count;
                o_state.sum_a      = sum_a_add;
                o_state.sum_b      = sum_b_add;
                o_state.byte_count = count_inc;
                if (count_inc == i_state.frame_length) begin
                    o_state.phase = PH_CK_A;
                end
                ev = EV_PAYLOAD;
            end
            PH_CK_A: begin
                o_state.rx_sum_a = i_byte;
                o_state.phase    = PH_CK_B;
                ev               = EV_FRAMING;
            end
            PH_CK_B: begin
                ev = sums_match ? EV_GOOD : EV_BAD;
                priority if (i_state.frame_class == NAV_CLASS &&
                             i_state.frame_ident == PVT_IDENT &&
                             i_state.frame_length >= PVT_MIN_LEN) begin
                    kind = KIND_PVT;
                end else if (i_state.frame_class == NAV_CLASS &&
                             i_state.frame_ident == HPPOS_IDENT &&
                             i_state.frame_length >= HPPOS_MIN_LEN) begin
                    kind = KIND_HPPOS;
                end else begin
                    kind = KIND_OTHER;
                end
                o_state.phase = PH_HUNT1;
            end
            default: begin
                // hunting, and any phase code with no meaning
                o_state.phase = (i_byte == SYNC_ONE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    assign o_result.event_res      = ev;
    assign o_result.data_byte      = i_byte;
    assign o_result.msg_class      = o_state.frame_class;
    assign o_result.msg_ident      = o_state.frame_ident;
    assign o_result.payload_index  = index;
    assign o_result.payload_length = o_state.frame_length;
    assign o_result.msg_kind       = kind;

endmodule

`default_nettype wire

### dv/ubx_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubx_frame_parser_tb: self-checking bench for the UBX frame parser
// Streams sync noise, well-formed frames, damaged and truncated frames into
// the parser, with random stalls on both streams, and checks every result
// word against a cycle-free parser model kept in the bench.
// ----------------------------------------------------------------------------

module ubx_frame_parser_tb;

    import ufp_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT     = 5000;
    localparam int MAX_PRINTS     = 100;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] data_byte, [15:8] msg_class, [23:16] msg_ident,
    // [39:24] payload_index, [55:40] payload_length
    logic [DATA_W-1:0]   m_axis_tdata;
    logic [USER_W-1:0]   m_axis_tuser;           // [2:0] event_res, [4:3] msg_kind

    ubx_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // bytes waiting to be sent, and the result words they must produce
    logic [7:0] rx_bytes[$];
    t_result    frame_events[$];

    int unsigned n_errors = 0;
    int unsigned n_queued = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    logic        hold_go = 1'b0;
    logic        rx_hold = 1'b0;
    int unsigned hold_cnt = 0;

    // parser model state
    logic [3:0]  ps_phase = PH_HUNT1;
    logic [7:0]  ps_class = '0;
    logic [7:0]  ps_ident = '0;
    logic [15:0] ps_length = '0;
    logic [15:0] ps_count = '0;
    logic [7:0]  ps_sum_a = '0;
    logic [7:0]  ps_sum_b = '0;
    logic [7:0]  ps_rx_a = '0;

    t_result seen_word;
    t_result want_word;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic fold_checksum(input logic [7:0] b);
        ps_sum_a = ps_sum_a + b;
        ps_sum_b = ps_sum_b + ps_sum_a;
    endtask

    // advance the parser model by one byte and queue the word it yields
    task automatic parse_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.event_res = EV_HUNT;
        r.msg_kind  = KIND_OTHER;
        case (ps_phase)
            PH_HUNT2: begin
                if (b == SYNC_TWO) begin
                    ps_class  = '0;
                    ps_ident  = '0;
                    ps_length = '0;
                    ps_count  = '0;
                    ps_sum_a  = '0;
                    ps_sum_b  = '0;
                    ps_phase  = PH_CLASS;
                end else if (b != SYNC_ONE) begin
                    ps_phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                ps_class = b;
                fold_checksum(b);
                r.event_res = EV_FRAMING;
                ps_phase = PH_IDENT;
            end
            PH_IDENT: begin
                ps_ident = b;
                fold_checksum(b);
                r.event_res = EV_FRAMING;
                ps_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                ps_length = {8'h00, b};
                fold_checksum(b);
                r.event_res = EV_FRAMING;
                ps_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                ps_length[15:8] = b;
                fold_checksum(b);
                r.event_res = EV_FRAMING;
                ps_count = '0;
                ps_phase = (ps_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                r.payload_index = ps_count;
                fold_checksum(b);
                r.event_res = EV_PAYLOAD;
                ps_count = ps_count + 16'd1;
                if (ps_count == ps_length) ps_phase = PH_CK_A;
            end
            PH_CK_A: begin
                ps_rx_a = b;
                r.event_res = EV_FRAMING;
                ps_phase = PH_CK_B;
            end
            PH_CK_B: begin
                r.event_res = (ps_rx_a == ps_sum_a && b == ps_sum_b) ? EV_GOOD : EV_BAD;
                if (ps_class == NAV_CLASS && ps_ident == PVT_IDENT && ps_length >= PVT_MIN_LEN)
                    r.msg_kind = KIND_PVT;
                else if (ps_class == NAV_CLASS && ps_ident == HPPOS_IDENT
                         && ps_length >= HPPOS_MIN_LEN)
                    r.msg_kind = KIND_HPPOS;
                ps_phase = PH_HUNT1;
            end
            default: begin
                ps_phase = (b == SYNC_ONE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        r.data_byte      = b;
        r.msg_class      = ps_class;
        r.msg_ident      = ps_ident;
        r.payload_length = ps_length;
        frame_events = {frame_events, r};
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        // cap the log; every mismatch still counts
        if (n_errors <= MAX_PRINTS)
            $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // sender: hold the word until taken, otherwise idle in bursts or offer the next byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
                void'(rx_bytes.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold
            end else if (tx_gap != 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_bytes.size() != 0 && $urandom_range(99) < tx_idle_pct) begin
                tx_gap = $urandom_range(9);
                s_axis_tvalid <= 1'b0;
            end else if (rx_bytes.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_bytes[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each taken word, then decide on ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_word.event_res      = m_axis_tuser[2:0];
                seen_word.msg_kind       = m_axis_tuser[4:3];
                seen_word.data_byte      = m_axis_tdata[7:0];
                seen_word.msg_class      = m_axis_tdata[15:8];
                seen_word.msg_ident      = m_axis_tdata[23:16];
                seen_word.payload_index  = m_axis_tdata[39:24];
                seen_word.payload_length = m_axis_tdata[55:40];
                if (frame_events.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, 0);
                end else begin
                    want_word = frame_events.pop_front();
                    if (seen_word.event_res != want_word.event_res)
                        report_mismatch("event_res", seen_word.event_res, want_word.event_res);
                    if (seen_word.data_byte != want_word.data_byte)
                        report_mismatch("data_byte", seen_word.data_byte, want_word.data_byte);
                    if (seen_word.msg_class != want_word.msg_class)
                        report_mismatch("msg_class", seen_word.msg_class, want_word.msg_class);
                    if (seen_word.msg_ident != want_word.msg_ident)
                        report_mismatch("msg_ident", seen_word.msg_ident, want_word.msg_ident);
                    if (seen_word.payload_index != want_word.payload_index)
                        report_mismatch("payload_index", seen_word.payload_index,
                                        want_word.payload_index);
                    if (seen_word.payload_length != want_word.payload_length)
                        report_mismatch("payload_length", seen_word.payload_length,
                                        want_word.payload_length);
                    if (seen_word.msg_kind != want_word.msg_kind)
                        report_mismatch("msg_kind", seen_word.msg_kind, want_word.msg_kind);
                end
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(99) < rx_idle_pct) begin
                rx_gap = $urandom_range(9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one long receiver hold-off, started once on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_go && !rx_hold && hold_cnt == 0) begin
            rx_hold  <= 1'b1;
            hold_cnt <= 1;
        end else if (rx_hold) begin
            if (hold_cnt == RX_HOLD_CYCLES) rx_hold <= 1'b0;
            else hold_cnt <= hold_cnt + 1;
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        rx_bytes = {rx_bytes, b};
        n_queued++;
    endtask

    // damage: 0 intact, 1 bad first checksum byte, 2 bad second, 3 cut short
    task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len, input int unsigned damage);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] v;
        logic [7:0] fb[$];
        int unsigned cut;
        ck_a = '0;
        ck_b = '0;
        fb = '{SYNC_ONE, SYNC_TWO, cls, id, len[7:0], len[15:8]};
        for (int i = 2; i < 6; i++) begin
            ck_a = ck_a + fb[i];
            ck_b = ck_b + ck_a;
        end
        for (int i = 0; i < len; i++) begin
            v = 8'($urandom);
            fb = {fb, v};
            ck_a = ck_a + v;
            ck_b = ck_b + ck_a;
        end
        if (damage == 1) ck_a = ck_a ^ (8'h01 << $urandom_range(7));
        if (damage == 2) ck_b = ck_b ^ (8'h01 << $urandom_range(7));
        fb = {fb, ck_a};
        fb = {fb, ck_b};
        cut = (damage == 3) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int i = 0; i < cut; i++) push_byte(fb[i]);
    endtask

    // noise and frames until n more bytes are queued
    task automatic queue_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        int unsigned damage;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                push_byte(SYNC_ONE);
                push_byte(SYNC_ONE);
            end else if (pick == 1) begin
                push_byte(SYNC_ONE);
                push_byte(8'($urandom));
            end
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
            cls = ($urandom_range(99) < 60) ? NAV_CLASS : 8'($urandom);
            case ($urandom_range(3))
                0:       id = PVT_IDENT;
                1:       id = HPPOS_IDENT;
                default: id = 8'($urandom);
            endcase
            case ($urandom_range(5))
                0:       len = 16'd0;
                1:       len = 16'($urandom_range(1, 8));
                2:       len = 16'(PVT_MIN_LEN - $urandom_range(1));
                3:       len = 16'(HPPOS_MIN_LEN - $urandom_range(1));
                default: len = 16'($urandom_range(60));
            endcase
            pick = $urandom_range(99);
            damage = (pick < 70) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 2 : 3;
            queue_frame(cls, id, len, damage);
        end
    endtask

    task automatic wait_drained;
        while (rx_bytes.size() != 0 || frame_events.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, stray second sync, repeated first sync,
        // empty payload, broken sync pair, bad checksum
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_TWO);
        push_byte(SYNC_ONE);
        queue_frame(NAV_CLASS, PVT_IDENT, 16'd0, 0);
        push_byte(SYNC_ONE);
        push_byte(8'h00);
        queue_frame(8'hFF, HPPOS_IDENT, 16'd0, 1);
        wait_drained();

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        queue_traffic(150);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_traffic(60);
        hold_go = 1'b1;
        wait_drained();
        hold_go = 1'b0;

        tx_idle_pct = 40;
        rx_idle_pct = 10;
        queue_traffic(100);
        wait_drained();

        // one frame whose declared length uses the high length byte
        tx_idle_pct = 5;
        rx_idle_pct = 5;
        queue_frame(NAV_CLASS, PVT_IDENT, 16'h0102, 0);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_traffic(80);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (frame_events.size() != 0)
            report_mismatch("missing words", 0, frame_events.size());
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
